### hdl/pojt_pkg.sv
// pojt_pkg: shared types and constants for the priority job timeline block
// no dependencies; imported by priority_order_job_timeline
package pojt_pkg;

  // payload field widths
  localparam int unsigned ID_W    = 16;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned TIME_W  = 20;

  // input item codes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  // largest tick the timeline can show
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // one stored job
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
  } job_entry_t;

endpackage

### hdl/priority_order_job_timeline.sv
// priority_order_job_timeline: non-preemptive priority scheduler over a job table
// depends on pojt_pkg (widths, mode codes, job entry type)

// A load transfer (mode 0) writes one job into the table; a load
// into a full table is dropped and sets the sticky dropped flag. A run transfer
// (mode 1) emits all stored jobs by falling priority, earlier load first on ties,
// each with its start and end tick on a timeline from zero that saturates at
// 2^20-1. Every result costs one pass over the table through its single
// registered read port, followed by the issue of the result and any output
// stall. A run on an empty table gives one result marked empty and last. The
// table is cleared after the last result. Input ready is low for the whole run.
module priority_order_job_timeline
  import pojt_pkg::*;
#(
  parameter int unsigned MAX_JOBS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 mode_i,
  input  logic [ID_W-1:0]      job_id_i,
  input  logic [PRIO_W-1:0]    priority_req_i,
  input  logic [BURST_W-1:0]   burst_length_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ID_W-1:0]      served_id_o,
  output logic [TIME_W-1:0]    start_time_o,
  output logic [TIME_W-1:0]    end_time_o,
  output logic                 last_o,
  output logic                 empty_run_o,
  output logic                 dropped_o
);

  localparam int unsigned IDXW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CNTW = $clog2(MAX_JOBS + 1);
  localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_JOBS);
  localparam logic [CNTW-1:0] CNT_ONE = CNTW'(1);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  // control registers
  logic [1:0]          state_q, state_d;
  logic [CNTW-1:0]     job_count_q, job_count_d;
  logic [CNTW-1:0]     issue_cnt_q, issue_cnt_d;
  logic [CNTW-1:0]     emit_cnt_q, emit_cnt_d;
  logic [MAX_JOBS-1:0] served_q, served_d;
  logic [TIME_W-1:0]   clock_q, clock_d;
  logic                drop_q, drop_d;
  logic                rd_vld_q, rd_vld_d;
  logic                found_q, found_d;
  logic                empty_q, empty_d;
  logic                out_valid_q, out_valid_d;

  // payload registers
  logic [IDXW-1:0]     rd_idx_q, rd_idx_d;
  logic [IDXW-1:0]     best_idx_q, best_idx_d;
  logic [PRIO_W-1:0]   best_prio_q, best_prio_d;
  logic [ID_W-1:0]     best_id_q, best_id_d;
  logic [BURST_W-1:0]  best_burst_q, best_burst_d;
  logic [ID_W-1:0]     out_id_q, out_id_d;
  logic [TIME_W-1:0]   out_start_q, out_start_d;
  logic [TIME_W-1:0]   out_end_q, out_end_d;
  logic                out_last_q, out_last_d;
  logic                out_empty_q, out_empty_d;
  logic                out_drop_q, out_drop_d;

  // job table
  job_entry_t          mem_q [MAX_JOBS];
  job_entry_t          rd_data_q;
  job_entry_t          wr_data;
  logic                wr_en;
  logic                rd_en;
  logic [IDXW-1:0]     rd_addr;

  logic                in_xfer;
  logic                out_free;
  logic                is_last;
  logic [TIME_W:0]     end_sum;
  logic [TIME_W-1:0]   end_sat;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign wr_en   = in_xfer && (mode_i == MODE_LOAD) && (job_count_q != CNT_MAX);
  assign wr_data = '{id: job_id_i, prio: priority_req_i, burst: burst_length_i};
  assign rd_en   = (state_q == ST_SCAN) && (issue_cnt_q != job_count_q);
  assign rd_addr = issue_cnt_q[IDXW-1:0];

  // saturating timeline add
  assign end_sum = {1'b0, clock_q} + (TIME_W+1)'(best_burst_q);
  assign end_sat = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];
  assign is_last = (emit_cnt_q == (job_count_q - CNT_ONE));

  // sequencer and shared compare
  always_comb begin
    state_d      = state_q;
    job_count_d  = job_count_q;
    issue_cnt_d  = issue_cnt_q;
    emit_cnt_d   = emit_cnt_q;
    served_d     = served_q;
    clock_d      = clock_q;
    drop_d       = drop_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    found_d      = found_q;
    empty_d      = empty_q;
    best_idx_d   = best_idx_q;
    best_prio_d  = best_prio_q;
    best_id_d    = best_id_q;
    best_burst_d = best_burst_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_id_d     = out_id_q;
    out_start_d  = out_start_q;
    out_end_d    = out_end_q;
    out_last_d   = out_last_q;
    out_empty_d  = out_empty_q;
    out_drop_d   = out_drop_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (mode_i == MODE_LOAD) begin
            if (job_count_q == CNT_MAX) begin
              drop_d = 1'b1;
            end else begin
              job_count_d = job_count_q + CNT_ONE;
            end
          end else begin
            empty_d     = (job_count_q == '0);
            issue_cnt_d = '0;
            emit_cnt_d  = '0;
            clock_d     = '0;
            found_d     = 1'b0;
            state_d     = (job_count_q == '0) ? ST_EMIT : ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // issue one table read per cycle
        if (rd_en) begin
          issue_cnt_d = issue_cnt_q + CNT_ONE;
          rd_vld_d    = 1'b1;
          rd_idx_d    = rd_addr;
        end
        // compare the entry read last cycle against the best so far
        if (rd_vld_q) begin
          if (!served_q[rd_idx_q] && (!found_q || (rd_data_q.prio > best_prio_q))) begin
            found_d      = 1'b1;
            best_idx_d   = rd_idx_q;
            best_prio_d  = rd_data_q.prio;
            best_id_d    = rd_data_q.id;
            best_burst_d = rd_data_q.burst;
          end
        end else if (issue_cnt_q == job_count_q) begin
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_id_d    = empty_q ? '0 : best_id_q;
          out_start_d = empty_q ? '0 : clock_q;
          out_end_d   = empty_q ? '0 : end_sat;
          out_last_d  = empty_q || is_last;
          out_empty_d = empty_q;
          out_drop_d  = drop_q;
          if (empty_q || is_last) begin
            job_count_d = '0;
            served_d    = '0;
            clock_d     = '0;
            state_d     = ST_IDLE;
          end else begin
            served_d[best_idx_q] = 1'b1;
            clock_d     = end_sat;
            emit_cnt_d  = emit_cnt_q + CNT_ONE;
            issue_cnt_d = '0;
            found_d     = 1'b0;
            state_d     = ST_SCAN;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_count_q <= '0;
      issue_cnt_q <= '0;
      emit_cnt_q  <= '0;
      served_q    <= '0;
      clock_q     <= '0;
      drop_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      job_count_q <= job_count_d;
      issue_cnt_q <= issue_cnt_d;
      emit_cnt_q  <= emit_cnt_d;
      served_q    <= served_d;
      clock_q     <= clock_d;
      drop_q      <= drop_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q     <= rd_idx_d;
    best_idx_q   <= best_idx_d;
    best_prio_q  <= best_prio_d;
    best_id_q    <= best_id_d;
    best_burst_q <= best_burst_d;
    out_id_q     <= out_id_d;
    out_start_q  <= out_start_d;
    out_end_q    <= out_end_d;
    out_last_q   <= out_last_d;
    out_empty_q  <= out_empty_d;
    out_drop_q   <= out_drop_d;
  end

  // job table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[job_count_q[IDXW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign served_id_o  = out_id_q;
  assign start_time_o = out_start_q;
  assign end_time_o   = out_end_q;
  assign last_o       = out_last_q;
  assign empty_run_o  = out_empty_q;
  assign dropped_o    = out_drop_q;

  // table fill never exceeds its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_count_q <= CNT_MAX)
    else $error("job count above table depth");

  // no job is marked served outside a run
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (served_q == '0))
    else $error("served mask not clear while idle");

  // served jobs never outnumber stored jobs
  a_served_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(served_q) <= int'(job_count_q))
    else $error("more jobs served than stored");

  // a non-empty result always has a chosen job behind it
  a_emit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !empty_q) |-> found_q)
    else $error("result issued without a selected job");

endmodule
